FILE: design/bm3_pkg.sv
// Shared types and constants for the 3x3 binary morphology block.
// Used by every module in the design folder except bm3_line_ram; depends on nothing.
package bm3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // column index, effective width, row index (row count reaches height + 1 while flushing)
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  // register file
  localparam int CFG_W  = 11;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam int CFG_RESET   = 1024;
  localparam int W_RESET_EFF = (CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET;
  localparam int H_RESET_EFF = (CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } reg_idx_t;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } morph_mode_t;

  // line memory word: {row before previous, previous row}
  localparam int LINE_W = 2;

  // 3x3 window, three columns of {bottom, middle, top}; newest column in the top bits
  localparam int WIN_W = 9;
  localparam logic [WIN_W-1:0] WIN_FULL      = 9'h1FF;
  localparam logic [WIN_W-1:0] MASK_NO_RIGHT = 9'h03F;
  localparam logic [WIN_W-1:0] MASK_NO_LEFT  = 9'h1F8;

  // result queue
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_LVL_W = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic pixel_in;
    logic drain;
  } pix_item_t;

  typedef struct packed {
    logic pixel_out;
    logic frame_last;
  } res_item_t;

  // per-pixel control handed from the scan counters to the window stage
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             pix;
    logic             col_first;
    logic             col_second;
    logic             top_ok;
    logic             mid_ok;
    logic             emit;
    logic             last;
  } stage_ctl_t;

endpackage

FILE: design/bm3_line_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the two line buffers; no package dependency.
module bm3_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/bm3_window.sv
// Window stage: line memory read-modify-write, 3x3 window shift and the AND/OR reduction.
// Depends on bm3_pkg and bm3_line_ram.
module bm3_window import bm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        issue,
  input  stage_ctl_t  issue_ctl,
  input  morph_mode_t morph_mode,
  input  logic        narrow,
  output logic        push,
  output res_item_t   push_item
);

  logic              s1_valid;
  stage_ctl_t        s1;
  logic [LINE_W-1:0] rd_data;
  logic [LINE_W-1:0] wr_data;
  logic [LINE_W-1:0] line_word;
  logic              fwd_hit;
  logic [LINE_W-1:0] fwd_data;
  logic              ra;
  logic              rb;
  logic [WIN_W-1:0]  window;
  logic [WIN_W-1:0]  window_next;
  logic [WIN_W-1:0]  eff;
  logic              result;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
      window   <= '0;
    end else begin
      s1_valid <= issue;
      // one-pixel-wide frames hit the same entry on consecutive pixels
      fwd_hit  <= issue && s1_valid && (issue_ctl.col == s1.col);
      if (s1_valid) begin
        window <= window_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1       <= issue_ctl;
    fwd_data <= wr_data;
  end

  bm3_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (LINE_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1.col),
    .wdata (wr_data),
    .re    (issue),
    .raddr (issue_ctl.col),
    .rdata (rd_data)
  );

  always_comb begin
    line_word   = fwd_hit ? fwd_data : rd_data;
    ra          = line_word[0] & s1.mid_ok;
    rb          = line_word[1] & s1.top_ok;
    wr_data     = {ra, s1.pix};
    window_next = {s1.pix, ra, rb, window[WIN_W-1:3]};
    eff         = window_next
                & (s1.col_first ? MASK_NO_RIGHT : WIN_FULL)
                & ((s1.col_second || narrow) ? MASK_NO_LEFT : WIN_FULL);
    case (morph_mode)
      MODE_DILATE: result = |eff;
      MODE_ERODE:  result = &eff;
      default:     result = &eff;
    endcase
    push                 = s1_valid && s1.emit;
    push_item.pixel_out  = result;
    push_item.frame_last = s1.last;
  end

endmodule

FILE: design/bm3_outq.sv
// Three-entry result queue between the window stage and the output channel.
// Depends on bm3_pkg.
module bm3_outq import bm3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  res_item_t             push_item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_item_t             res_data,
  output logic [OUTQ_LVL_W-1:0] level
);

  res_item_t               slots [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   rd_ptr;
  logic [OUTQ_PTR_W-1:0]   wr_ptr;
  logic                    pop;

  assign res_valid = (level != '0);
  assign pop       = res_valid && res_ready;
  assign res_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr + OUTQ_PTR_W'(1);
      end
      level <= level + OUTQ_LVL_W'(push) - OUTQ_LVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: design/binary_morphology_3x3.sv
// Top level of the streaming 3x3 binary erosion/dilation block: register file and scan counters.
// Depends on bm3_pkg, bm3_window (with bm3_line_ram) and bm3_outq.
//
//   channel   signals                                  carries
//   pix       pix_valid / pix_ready / pix_data         pixel_in, drain
//   res       res_valid / res_ready / res_data         pixel_out, frame_last
//   apb       psel penable pwrite paddr pwdata prdata   frame_width, frame_height, morph_mode
//
// One pixel per clock while pix_ready is high; the line memory's single read and single write port per cycle set it.
// A result passes the registered window stage and is then written into the queue before it can leave.
// Result n of a frame follows input n + width + 1; width + 1 drain transactions flush the end.
// Reset clears counters, window and queue; the line memory needs no clearing.
// pix_ready drops only when the three-entry result queue could overflow.
module binary_morphology_3x3 import bm3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              pix_valid,
  output logic              pix_ready,
  input  pix_item_t         pix_data,
  output logic              res_valid,
  input  logic              res_ready,
  output res_item_t         res_data
);

  logic [CFG_W-1:0]      cfg_width;
  logic [CFG_W-1:0]      cfg_height;
  morph_mode_t           cfg_mode;
  logic [WID_W-1:0]      w_eff;
  logic [ROW_W-1:0]      h_eff;
  logic                  narrow;
  logic [COL_W-1:0]      col_idx;
  logic [ROW_W-1:0]      row_idx;

  logic                  cfg_wr;
  reg_idx_t              reg_sel;
  logic [CFG_W-1:0]      wr_val;
  logic [WID_W-1:0]      sat_w;
  logic [ROW_W-1:0]      sat_h;
  logic                  geom_wr;

  logic                  skip;
  logic                  work;
  logic [ROW_W-1:0]      h_plus;
  logic                  col_wrap;
  stage_ctl_t            ctl;

  logic                  push;
  res_item_t             push_item;
  logic [OUTQ_LVL_W-1:0] q_level;

  // ---------------- register file ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_val  = pwdata[CFG_W-1:0];
  assign geom_wr = cfg_wr && (reg_sel == REG_WIDTH || reg_sel == REG_HEIGHT);

  always_comb begin
    if (wr_val == '0) begin
      sat_w = WID_W'(1);
      sat_h = ROW_W'(1);
    end else begin
      sat_w = (32'(wr_val) > 32'(MAX_WIDTH))  ? WID_W'(MAX_WIDTH)  : WID_W'(wr_val);
      sat_h = (32'(wr_val) > 32'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : ROW_W'(wr_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= CFG_W'(CFG_RESET);
      cfg_height <= CFG_W'(CFG_RESET);
      cfg_mode   <= MODE_ERODE;
      w_eff      <= WID_W'(W_RESET_EFF);
      h_eff      <= ROW_W'(H_RESET_EFF);
      narrow     <= (W_RESET_EFF == 1);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_WIDTH: begin
          cfg_width <= wr_val;
          w_eff     <= sat_w;
          narrow    <= (sat_w == WID_W'(1));
        end
        REG_HEIGHT: begin
          cfg_height <= wr_val;
          h_eff      <= sat_h;
        end
        REG_MODE: begin
          cfg_mode <= morph_mode_t'(pwdata[0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = DATA_W'(cfg_width);
      REG_HEIGHT: prdata = DATA_W'(cfg_height);
      REG_MODE:   prdata = DATA_W'(cfg_mode);
      default:    prdata = '0;
    endcase
  end

  // ---------------- scan counters ----------------
  // a drain before the first pixel of a frame is swallowed without effect
  assign skip      = pix_data.drain && (col_idx == '0) && (row_idx == '0);
  assign pix_ready = (32'(q_level) + 32'(push)) < 32'(OUTQ_DEPTH);
  assign work      = pix_valid && pix_ready && !skip;
  assign h_plus    = h_eff + ROW_W'(1);
  assign col_wrap  = (WID_W'(col_idx) + WID_W'(1)) == w_eff;

  always_comb begin
    ctl.col        = col_idx;
    ctl.pix        = pix_data.pixel_in && !pix_data.drain && (row_idx < h_eff);
    ctl.col_first  = (col_idx == '0);
    ctl.col_second = (col_idx == COL_W'(1));
    ctl.top_ok     = (row_idx >= ROW_W'(2)) && (row_idx <= h_plus);
    ctl.mid_ok     = (row_idx >= ROW_W'(1)) && (row_idx <= h_eff);
    ctl.emit       = (row_idx >= ROW_W'(2)) || ((row_idx == ROW_W'(1)) && (col_idx != '0));
    // last output lands on column 0 of the second flush row
    ctl.last       = (row_idx == h_plus);
  end

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      col_idx <= '0;
      row_idx <= '0;
    end else if (work) begin
      if (ctl.last) begin
        col_idx <= '0;
        row_idx <= '0;
      end else if (col_wrap) begin
        col_idx <= '0;
        row_idx <= row_idx + ROW_W'(1);
      end else begin
        col_idx <= col_idx + COL_W'(1);
      end
    end
  end

  // ---------------- datapath ----------------
  bm3_window u_window (
    .clk        (clk),
    .rst        (rst),
    .issue      (work),
    .issue_ctl  (ctl),
    .morph_mode (cfg_mode),
    .narrow     (narrow),
    .push       (push),
    .push_item  (push_item)
  );

  bm3_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .level     (q_level)
  );

`ifndef SYNTH
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_level < OUTQ_LVL_W'(OUTQ_DEPTH)))
    else $error("result queue overflow");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (work && ctl.last) |=> (col_idx == '0 && row_idx == '0))
    else $error("scan counters not cleared after last pixel");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    WID_W'(col_idx) < w_eff)
    else $error("column counter beyond frame width");
`endif

endmodule
